// ----- rtl/core/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types and codes of the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int ADDR_W = 32;
  localparam int USED_W = 17;
  localparam int STAT_W = 3;
  localparam int REQ_W  = 2;
  localparam int WORD_W = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_OOM   = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STAT_W-1:0] ST_ALIGN = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREE  = 3'd4;

  // configuration register indexes
  localparam logic CFG_BASE_ADDR = 1'b0;
  localparam logic CFG_KEND_ADDR = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] free_addr;
  } bpa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    logic [STAT_W-1:0] status;
    logic [USED_W-1:0] used_count;
  } bpa_rsp_t;

endpackage

// ----- rtl/core/bitmap_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// physical page allocator keeping one used bit per page in a word memory
// ----------------------------------------------------------------------------
// usage
//   requests come in on start / in_req and are taken when start is high and
//   busy is low; one request at a time, the next one can be taken in the
//   cycle the result is shown
//   every request gives exactly one result item, shown for one cycle with
//   out_valid high; the receiver cannot stall, so the result must be taken
//   cfg_we / cfg_index / cfg_wdata write the page 0 base address (index 0)
//   and the kernel end address (index 1) at once; the user must write them
//   only while busy is low, as the block itself does not enforce it
// request steps (W = ceil(NUM_PAGES / 32) bitmap words)
//   init     fill pass over all W bitmap words, one word written per cycle
//   alloc    scans words up to one with a free page, out of memory if none;
//            the bitmap read port gives one word per cycle
//   free     range check, word read, bit update; a range or alignment
//            failure ends it at the check
//   unknown  the result shows in the cycle right after the accept
// reset
//   a fill pass over all W words marks every page used; busy stays high meanwhile
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
  parameter int NUM_PAGES = 65536,
  parameter int PAGE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  bpa_pkg::bpa_req_t                in_req,
  // result channel
  output logic                             out_valid,
  output bpa_pkg::bpa_rsp_t                out_rsp,
  // configuration
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]       cfg_wdata
);

  import bpa_pkg::*;

  // geometry
  localparam int MAP_WORDS = (NUM_PAGES + 31) / 32;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PG_W      = AW + 5;
  localparam int CNT_W     = $clog2(NUM_PAGES + 1);
  localparam int SW_W      = CNT_W - 5;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [32:0]   PG_MASK   = (33'd1 << PAGE_BITS) - 33'd1;
  // bits of the last word that belong to no page stay set for good
  localparam logic [WORD_W-1:0] PAD_MASK = ((NUM_PAGES % 32) == 0) ? '0 :
    ~((32'd1 << (NUM_PAGES % 32)) - 32'd1);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b0000000001,
    S_INIT_RND   = 10'b0000000010,
    S_INIT_START = 10'b0000000100,
    S_FILL       = 10'b0000001000,
    S_ALLOC_SCAN = 10'b0000010000,
    S_ALLOC_SET  = 10'b0000100000,
    S_ALLOC_ADDR = 10'b0001000000,
    S_FREE_CHK   = 10'b0010000000,
    S_FREE_RD    = 10'b0100000000,
    S_FREE_UPD   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [ADDR_W-1:0] phys_r, kend_r;

  // control
  logic [AW-1:0]    idx_r, idx_nxt;          // fill / scan word pointer
  logic             issue_r, issue_nxt;      // scan reads still to issue
  logic             chk_v_r, chk_v_nxt;      // read data valid this cycle
  logic [AW-1:0]    chk_addr_r, chk_addr_nxt;
  logic             fill_rsp_r, fill_rsp_nxt; // fill pass ends in a result
  logic [CNT_W-1:0] start_r, start_nxt;      // first free page of the fill
  logic [CNT_W-1:0] cnt_r, cnt_nxt;          // used page count

  // payload
  logic [ADDR_W-1:0] free_addr_r, free_addr_nxt;
  logic [32:0]       rounded_r, rounded_nxt;
  logic [PG_W-1:0]   page_r, page_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;

  // result register
  logic     out_valid_r, out_valid_nxt;
  bpa_rsp_t out_rsp_r, out_rsp_nxt;

  // memory port
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  // datapath helpers
  logic [WORD_W-1:0] fill_word;
  logic [SW_W-1:0]   idx_ext;
  logic [WORD_W-1:0] avail, onehot;
  logic [4:0]        bit_idx;
  logic [33:0]       idiff;
  logic [63:0]       ipg64;
  logic [32:0]       fdiff;
  logic [63:0]       fpg64;
  logic [63:0]       pg_off;

  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // word written by the fill pass: pages below the start stay used
  always_comb begin
    idx_ext = SW_W'(idx_r);
    if (idx_ext < start_r[CNT_W-1:5]) begin
      fill_word = '1;
    end else if (idx_ext == start_r[CNT_W-1:5]) begin
      fill_word = ~({WORD_W{1'b1}} << start_r[4:0]);
    end else begin
      fill_word = '0;
    end
    if (idx_r == LAST_WORD) begin
      fill_word = fill_word | PAD_MASK;
    end
  end

  // lowest free page of the word just read
  always_comb begin
    avail   = ~mem_rdata;
    onehot  = avail & (~avail + 32'd1);
    bit_idx = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (onehot[j]) begin
        bit_idx = bit_idx | 5'(j);
      end
    end
  end

  // arithmetic for init and free
  always_comb begin
    rounded_nxt = ({1'b0, kend_r} + PG_MASK) & ~PG_MASK;
    idiff       = {1'b0, rounded_r} - {2'b00, phys_r};
    ipg64       = 64'(idiff[32:0] >> PAGE_BITS);
    fdiff       = {1'b0, free_addr_r} - {1'b0, phys_r};
    fpg64       = 64'(fdiff[31:0] >> PAGE_BITS);
    pg_off      = 64'(page_r) << PAGE_BITS;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    issue_nxt     = issue_r;
    chk_v_nxt     = 1'b0;
    chk_addr_nxt  = idx_r;
    fill_rsp_nxt  = fill_rsp_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    free_addr_nxt = free_addr_r;
    page_nxt      = page_r;
    word_nxt      = word_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = fill_word;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          free_addr_nxt = in_req.free_addr;
          unique case (in_req.req_type)
            REQ_INIT: begin
              state_nxt = S_INIT_RND;
            end
            REQ_ALLOC: begin
              idx_nxt   = '0;
              issue_nxt = 1'b1;
              state_nxt = S_ALLOC_SCAN;
            end
            REQ_FREE: begin
              state_nxt = S_FREE_CHK;
            end
            default: begin
              // unknown request: no change, plain result
              out_valid_nxt          = 1'b1;
              out_rsp_nxt.page_addr  = '0;
              out_rsp_nxt.status     = ST_OK;
              out_rsp_nxt.used_count = USED_W'(cnt_r);
            end
          endcase
        end
      end

      S_INIT_RND: begin
        state_nxt = S_INIT_START;
      end

      S_INIT_START: begin
        // kernel end rounded up to a page at or below the base frees everything
        if (idiff[33] || (idiff == '0)) begin
          start_nxt = '0;
        end else if (ipg64 > 64'(NUM_PAGES)) begin
          start_nxt = CNT_W'(NUM_PAGES);
        end else begin
          start_nxt = CNT_W'(ipg64);
        end
        cnt_nxt      = start_nxt;
        idx_nxt      = '0;
        fill_rsp_nxt = 1'b1;
        state_nxt    = S_FILL;
      end

      S_FILL: begin
        mem_we = 1'b1;
        if (idx_r == LAST_WORD) begin
          state_nxt = S_IDLE;
          if (fill_rsp_r) begin
            out_valid_nxt          = 1'b1;
            out_rsp_nxt.page_addr  = '0;
            out_rsp_nxt.status     = ST_OK;
            out_rsp_nxt.used_count = USED_W'(cnt_r);
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_ALLOC_SCAN: begin
        // one read issued per cycle, data checked in the cycle after
        mem_re    = issue_r;
        chk_v_nxt = issue_r;
        if (issue_r) begin
          if (idx_r == LAST_WORD) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
        if (chk_v_r && (mem_rdata != '1)) begin
          page_nxt  = {chk_addr_r, bit_idx};
          word_nxt  = mem_rdata | onehot;
          issue_nxt = 1'b0;
          state_nxt = S_ALLOC_SET;
        end else if (chk_v_r && (chk_addr_r == LAST_WORD)) begin
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.page_addr  = '0;
          out_rsp_nxt.status     = ST_OOM;
          out_rsp_nxt.used_count = USED_W'(cnt_r);
          state_nxt              = S_IDLE;
        end
      end

      S_ALLOC_SET: begin
        mem_we    = 1'b1;
        mem_waddr = page_r[PG_W-1:5];
        mem_wdata = word_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_ALLOC_ADDR;
      end

      S_ALLOC_ADDR: begin
        out_valid_nxt          = 1'b1;
        out_rsp_nxt.page_addr  = phys_r + pg_off[ADDR_W-1:0];
        out_rsp_nxt.status     = ST_OK;
        out_rsp_nxt.used_count = USED_W'(cnt_r);
        state_nxt              = S_IDLE;
      end

      S_FREE_CHK: begin
        page_nxt = PG_W'(fdiff[31:0] >> PAGE_BITS);
        // range check comes before the alignment check
        if (fdiff[32] || (fpg64 >= 64'(NUM_PAGES))) begin
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.page_addr  = '0;
          out_rsp_nxt.status     = ST_RANGE;
          out_rsp_nxt.used_count = USED_W'(cnt_r);
          state_nxt              = S_IDLE;
        end else if (free_addr_r[PAGE_BITS-1:0] != '0) begin
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.page_addr  = '0;
          out_rsp_nxt.status     = ST_ALIGN;
          out_rsp_nxt.used_count = USED_W'(cnt_r);
          state_nxt              = S_IDLE;
        end else begin
          state_nxt = S_FREE_RD;
        end
      end

      S_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = page_r[PG_W-1:5];
        state_nxt = S_FREE_UPD;
      end

      S_FREE_UPD: begin
        out_valid_nxt         = 1'b1;
        out_rsp_nxt.page_addr = '0;
        state_nxt             = S_IDLE;
        if (!mem_rdata[page_r[4:0]]) begin
          out_rsp_nxt.status     = ST_FREE;
          out_rsp_nxt.used_count = USED_W'(cnt_r);
        end else begin
          mem_we                 = 1'b1;
          mem_waddr              = page_r[PG_W-1:5];
          mem_wdata              = mem_rdata & ~(32'd1 << page_r[4:0]);
          cnt_nxt                = cnt_r - CNT_W'(1);
          out_rsp_nxt.status     = ST_OK;
          out_rsp_nxt.used_count = USED_W'(cnt_nxt);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers; reset starts the fill pass that reserves every page
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      idx_r       <= '0;
      issue_r     <= 1'b0;
      chk_v_r     <= 1'b0;
      fill_rsp_r  <= 1'b0;
      start_r     <= CNT_W'(NUM_PAGES);
      cnt_r       <= CNT_W'(NUM_PAGES);
      out_valid_r <= 1'b0;
      phys_r      <= '0;
      kend_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      issue_r     <= issue_nxt;
      chk_v_r     <= chk_v_nxt;
      fill_rsp_r  <= fill_rsp_nxt;
      start_r     <= start_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_ADDR: phys_r <= cfg_wdata;
          CFG_KEND_ADDR: kend_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_addr_r  <= chk_addr_nxt;
    free_addr_r <= free_addr_nxt;
    rounded_r   <= rounded_nxt;
    page_r      <= page_nxt;
    word_r      <= word_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // checks

  // used count never goes beyond the managed range
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_PAGES))
    else $error("used page count out of range");

  // the bitmap is only written by the fill pass and the two update steps
  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_FILL || state_r == S_ALLOC_SET ||
                state_r == S_FREE_UPD))
    else $error("bitmap written outside an update step");

  // a successful alloc raises the count by one
  a_alloc_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC_SET) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("alloc did not count its page");

  // a result always ends the work on a request
  a_rsp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE || $past(state_r == S_IDLE)))
    else $error("result given while still busy");

endmodule

// ----- rtl/core/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- dv/tb_bitmap_page_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_core
// self-checking bench for the bitmap page allocator core
// ----------------------------------------------------------------------------
// a short table of hand-picked requests walks the reset state, address wrap,
// kernel end clamping at both ends and every error status; then randomised
// layouts are set up, the map is rebuilt and alloc / free traffic is thrown at
// it under three sender idling patterns. a bit-exact copy of the allocator
// state predicts each result not typed into the table; all compared field by field
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator_core;
  import bpa_pkg::*;

  localparam int NUM_PAGES = 65536;
  localparam int PAGE_BITS = 12;
  localparam int MAP_WORDS = (NUM_PAGES + 31) / 32;
  localparam logic [63:0] PG_MASK = (64'd1 << PAGE_BITS) - 64'd1;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;  // unused code, block just echoes the count
  localparam int STALL_LIMIT = 20000;            // longer than a full bitmap scan
  localparam int SHOWN_MISMATCHES = 10;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    bpa_req_t    req;
    logic        cfg_idx;
    logic [31:0] cfg_val;
    bit          typed;     // result written into the row by hand
    bpa_rsp_t    want;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  bpa_req_t in_req;
  logic     out_valid;
  bpa_rsp_t out_rsp;
  logic     cfg_we;
  logic     cfg_index;
  logic [ADDR_W-1:0] cfg_wdata;

  // shadow copy of the allocator
  bit   [31:0] page_map [MAP_WORDS];
  int unsigned pages_in_use;
  logic [31:0] base_addr;
  logic [31:0] kend_addr;

  bpa_rsp_t    pending_rsp [$];   // results owed by the block, oldest first
  logic [31:0] held_pages [$];    // pages handed out since the last init
  dir_row_t    dir_rows [$];

  int idle_pct;
  int stall_cycles;
  int mismatches;
  int items_sent;
  int layouts;
  int status_seen [5];
  bpa_rsp_t want_rsp;

  bitmap_page_allocator_core #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // allocator shadow: applies one request and returns the result it gives
  // ---------------------------------------------------------------------------
  function automatic bpa_rsp_t allocator_step(input bpa_req_t r);
    bpa_rsp_t    res;
    logic [63:0] rounded;
    logic [63:0] low_pg;
    logic [63:0] range_end;
    logic [31:0] pg;
    int          w;
    int          b;
    bit          found;

    res = '0;
    case (r.req_type)
      REQ_INIT: begin
        foreach (page_map[i]) page_map[i] = '1;
        // round up without 32-bit wrap, the boundary may sit at 2^32
        rounded = (64'(kend_addr) + PG_MASK) & ~PG_MASK;
        if (rounded <= 64'(base_addr)) low_pg = 64'd0;
        else low_pg = (rounded - 64'(base_addr)) >> PAGE_BITS;
        if (low_pg > 64'(NUM_PAGES)) low_pg = 64'(NUM_PAGES);
        for (int p = int'(low_pg); p < NUM_PAGES; p++) page_map[p >> 5][p & 31] = 1'b0;
        pages_in_use = int'(low_pg);
      end
      REQ_ALLOC: begin
        found = 1'b0;
        res.status = ST_OOM;
        for (w = 0; w < MAP_WORDS && !found; w++) begin
          if (page_map[w] != '1) begin
            b = 0;
            while (b < 31 && page_map[w][b]) b++;
            page_map[w][b] = 1'b1;
            pages_in_use++;
            pg = 32'((w << 5) | b);
            res.page_addr = base_addr + (pg << PAGE_BITS);  // wraps mod 2^32
            res.status = ST_OK;
            found = 1'b1;
          end
        end
      end
      REQ_FREE: begin
        range_end = 64'(base_addr) + (64'(NUM_PAGES) << PAGE_BITS);
        // range before alignment, and a failed free leaves the map alone
        if (r.free_addr < base_addr || 64'(r.free_addr) >= range_end) begin
          res.status = ST_RANGE;
        end else if ((64'(r.free_addr) & PG_MASK) != 64'd0) begin
          res.status = ST_ALIGN;
        end else begin
          pg = (r.free_addr - base_addr) >> PAGE_BITS;
          if (!page_map[pg >> 5][pg[4:0]]) begin
            res.status = ST_FREE;
          end else begin
            page_map[pg >> 5][pg[4:0]] = 1'b0;
            pages_in_use--;
            res.status = ST_OK;
          end
        end
      end
      default: ;  // unknown code: nothing moves
    endcase
    res.used_count = pages_in_use[USED_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------
  function automatic void add_req(input logic [REQ_W-1:0] rt, input logic [31:0] a,
                                  input bit typed, input logic [STAT_W-1:0] st,
                                  input logic [31:0] pa, input logic [USED_W-1:0] cnt);
    dir_row_t row;
    row.kind = ROW_REQ;
    row.req.req_type = rt;
    row.req.free_addr = a;
    row.cfg_idx = 1'b0;
    row.cfg_val = '0;
    row.typed = typed;
    row.want.page_addr = pa;
    row.want.status = st;
    row.want.used_count = cnt;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic idx, input logic [31:0] v);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.req = '0;
    row.cfg_idx = idx;
    row.cfg_val = v;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  // offers one item, holding it until the block takes it
  task automatic issue(input bpa_req_t r, input bit typed, input bpa_rsp_t want);
    bpa_rsp_t calc;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    // taken at this edge
    calc = allocator_step(r);
    pending_rsp.push_back(typed ? want : calc);
    items_sent++;
    if (r.req_type == REQ_INIT) held_pages.delete();
    if (r.req_type == REQ_ALLOC && calc.status == ST_OK) held_pages.push_back(calc.page_addr);
  endtask

  // stop offering and let every owed result come back before touching registers
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    if (idx == CFG_BASE_ADDR) base_addr = v;
    else kend_addr = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES)
      $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (out_rsp.status <= ST_FREE) status_seen[out_rsp.status]++;
      if (pending_rsp.size() == 0) begin
        flag_mismatch("unowed result item, page_addr", '0, out_rsp.page_addr);
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (out_rsp.page_addr !== want_rsp.page_addr)
          flag_mismatch("page_addr", want_rsp.page_addr, out_rsp.page_addr);
        if (out_rsp.status !== want_rsp.status)
          flag_mismatch("status", 32'(want_rsp.status), 32'(out_rsp.status));
        if (out_rsp.used_count !== want_rsp.used_count)
          flag_mismatch("used_count", 32'(want_rsp.used_count), 32'(out_rsp.used_count));
      end
    end
  end

  // watchdog: cycles in which nothing at all moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    bpa_req_t    req;
    logic [31:0] a;
    int          pick;
    int          n;
    int          k;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= 1'b0;
    cfg_wdata <= '0;
    stall_cycles = 0;
    mismatches = 0;
    items_sent = 0;
    layouts = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (page_map[i]) page_map[i] = '1;
    pages_in_use = NUM_PAGES;
    base_addr = '0;
    kend_addr = '0;
    idle_pct = 25;

    // reset state: every page reserved, base 0
    add_req(REQ_ALLOC, 32'h0000_0000, 1, ST_OOM,   32'h0, 17'd65536);
    add_req(REQ_FREE,  32'h0000_0000, 1, ST_OK,    32'h0, 17'd65535);
    add_req(REQ_FREE,  32'h0000_0000, 1, ST_FREE,  32'h0, 17'd65535);
    add_req(REQ_FREE,  32'h1000_0000, 1, ST_RANGE, 32'h0, 17'd65535);  // one past the top
    add_req(REQ_FREE,  32'h0000_0fff, 1, ST_ALIGN, 32'h0, 17'd65535);
    add_req(REQ_NONE,  32'hffff_ffff, 1, ST_OK,    32'h0, 17'd65535);
    add_req(REQ_ALLOC, 32'h0000_0000, 1, ST_OK,    32'h0, 17'd65536);
    // base in the last page of the address space, kernel end below it
    add_cfg(CFG_BASE_ADDR, 32'hffff_f000);
    add_cfg(CFG_KEND_ADDR, 32'h0000_0000);
    add_req(REQ_INIT,  32'h0000_0000, 1, ST_OK,    32'h0, 17'd0);
    add_req(REQ_ALLOC, 32'h0000_0000, 1, ST_OK,    32'hffff_f000, 17'd1);
    add_req(REQ_ALLOC, 32'h0000_0000, 1, ST_OK,    32'h0000_0000, 17'd2);  // address wraps
    add_req(REQ_FREE,  32'hffff_e000, 1, ST_RANGE, 32'h0, 17'd2);
    add_req(REQ_FREE,  32'hffff_ffff, 1, ST_ALIGN, 32'h0, 17'd2);
    add_req(REQ_FREE,  32'hffff_f000, 1, ST_OK,    32'h0, 17'd1);
    // kernel end rounds to 2^32: clamps past the range, nothing freed
    add_cfg(CFG_BASE_ADDR, 32'h0000_0000);
    add_cfg(CFG_KEND_ADDR, 32'hffff_ffff);
    add_req(REQ_INIT,  32'h0000_0000, 1, ST_OK,    32'h0, 17'd65536);
    add_req(REQ_ALLOC, 32'h0000_0000, 1, ST_OOM,   32'h0, 17'd65536);
    // only the top page left free
    add_cfg(CFG_KEND_ADDR, 32'h0fff_e001);
    add_req(REQ_INIT,  32'h0000_0000, 1, ST_OK,    32'h0, 17'd65535);
    add_req(REQ_ALLOC, 32'h0000_0000, 0, ST_OK,    32'h0, 17'd0);
    add_req(REQ_FREE,  32'h0fff_f000, 0, ST_OK,    32'h0, 17'd0);
    add_req(REQ_FREE,  32'h0fff_f000, 1, ST_FREE,  32'h0, 17'd65535);
    add_req(REQ_NONE,  32'h0000_0000, 0, ST_OK,    32'h0, 17'd0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, straight after the fill pass
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
        layouts++;
      end else begin
        issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random part: three idling patterns, three memory layouts each
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 25 : (ph == 1) ? 88 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        // sender holds off until the block has answered everything
        wait_idle();
        pick = $urandom_range(3);
        case (pick)
          0: begin
            a = $urandom & 32'hffff_f000;
            write_reg(CFG_BASE_ADDR, a);
            write_reg(CFG_KEND_ADDR, a + ($urandom_range(48) << PAGE_BITS) + $urandom_range(4095));
          end
          1: begin
            a = $urandom;  // base off a page boundary
            write_reg(CFG_BASE_ADDR, a);
            write_reg(CFG_KEND_ADDR, a + ($urandom_range(40) << PAGE_BITS));
          end
          2: begin
            // anywhere at all, so long scans and running dry both show up
            write_reg(CFG_BASE_ADDR, $urandom);
            write_reg(CFG_KEND_ADDR, $urandom);
          end
          default: begin
            write_reg(CFG_BASE_ADDR, $urandom_range(16) << PAGE_BITS);
            write_reg(CFG_KEND_ADDR, 32'h0000_0000);
          end
        endcase
        layouts++;
        req.req_type = REQ_INIT;
        req.free_addr = $urandom;
        issue(req, 1'b0, '0);

        for (n = 0; n < 41; n++) begin
          pick = $urandom_range(99);
          req.free_addr = $urandom;
          if (pick < 45) begin
            req.req_type = REQ_ALLOC;
          end else if (pick < 70) begin
            // hand back a page we were given, or allocate if none is held
            if (held_pages.size() != 0) begin
              k = $urandom_range(held_pages.size() - 1);
              req.req_type = REQ_FREE;
              req.free_addr = held_pages[k];
              held_pages.delete(k);
            end else begin
              req.req_type = REQ_ALLOC;
            end
          end else if (pick < 80) begin
            // aligned page near the bottom: kernel pages, held or already free
            req.req_type = REQ_FREE;
            req.free_addr = base_addr + ($urandom_range(63) << PAGE_BITS);
          end else if (pick < 88) begin
            req.req_type = REQ_FREE;
            case ($urandom_range(2))
              0: req.free_addr = base_addr + (32'(NUM_PAGES) << PAGE_BITS);
              1: req.free_addr = base_addr - (32'd1 << PAGE_BITS);
              default: ;  // plain noise
            endcase
          end else if (pick < 93) begin
            req.req_type = REQ_FREE;
            req.free_addr = base_addr + ($urandom_range(63) << PAGE_BITS)
                            + $urandom_range(4095, 1);
          end else if (pick < 97) begin
            req.req_type = REQ_NONE;
          end else begin
            req.req_type = REQ_INIT;
          end
          issue(req, 1'b0, '0);
        end
      end
    end

    // wind down: everything back, then a wait for stray items
    wait_idle();
    repeat (16) @(posedge clk);
    if (pending_rsp.size() != 0) flag_mismatch("results still owed", 32'd0,
                                                32'(pending_rsp.size()));

    $display("covered %0d items over %0d register settings and three idling patterns",
             items_sent, layouts);
    $display("statuses seen: ok %0d, out of memory %0d, range %0d, misaligned %0d, free %0d",
             status_seen[ST_OK], status_seen[ST_OOM], status_seen[ST_RANGE],
             status_seen[ST_ALIGN], status_seen[ST_FREE]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
